FILE: hdl/gcode_xyz_field_parser_core_assert.svh
// assertion macros for the checker file of the field parser
// no dependencies; clock clk_i and reset rst_ni must be in scope at the point of use
`ifndef GCODE_XYZ_FIELD_PARSER_CORE_ASSERT_SVH
`define GCODE_XYZ_FIELD_PARSER_CORE_ASSERT_SVH

// checked only outside reset
`define GXFP_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define GXFP_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hdl/gxfp_pkg.sv
// shared types, constants and helper functions of the g-code field parser
// no dependencies
package gxfp_pkg;

  // number format
  localparam int FracDigits = 3;
  localparam int ValueBits  = 32;
  localparam int MagW       = ValueBits;
  localparam int CoordW     = 32;
  localparam int FcW        = (FracDigits < 1) ? 1 : $clog2(FracDigits + 1);
  localparam int ScaleMax   = 10 ** FracDigits;
  localparam int ScaleW     = $clog2(ScaleMax + 1);
  localparam int ProdW      = MagW + ScaleW;

  // stream widths
  localparam int CharW   = 8;
  localparam int KindW   = 2;
  localparam int OutBits = KindW + 3 * CoordW;
  localparam int OutW    = ((OutBits + 7) / 8) * 8;

  // characters
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChSpace   = 8'd32;
  localparam logic [CharW-1:0] ChPlus    = 8'h2b;
  localparam logic [CharW-1:0] ChMinus   = 8'h2d;
  localparam logic [CharW-1:0] ChPoint   = 8'h2e;
  localparam logic [CharW-1:0] ChUpperX  = 8'h58;
  localparam logic [CharW-1:0] ChUpperY  = 8'h59;
  localparam logic [CharW-1:0] ChUpperZ  = 8'h5a;

  // axis codes
  localparam logic [1:0] AxisNone = 2'd0;
  localparam logic [1:0] AxisX    = 2'd1;
  localparam logic [1:0] AxisY    = 2'd2;
  localparam logic [1:0] AxisZ    = 2'd3;

  // line kind codes
  localparam logic [KindW-1:0] KindNone = 2'd0;
  localparam logic [KindW-1:0] KindXy   = 2'd1;
  localparam logic [KindW-1:0] KindZ    = 2'd2;

  // character classes of one beat
  typedef struct packed {
    logic       is_nl;
    logic       is_letter;
    logic       is_digit;
    logic       is_blank;
    logic       is_sign;
    logic       is_minus;
    logic       is_point;
    logic [1:0] axis;
    logic [3:0] digit;
  } gxfp_cls_t;

  // state of the number being read
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
    logic [FcW-1:0]  fc;
  } gxfp_num_t;

  // magnitude limit 2^(ValueBits-1)
  localparam logic [MagW-1:0] MagLimit = {1'b1, {(MagW-1){1'b0}}};

  function automatic gxfp_cls_t gxfp_classify(input logic [CharW-1:0] c);
    gxfp_cls_t        r;
    logic [CharW-1:0] u;
    u           = c & 8'hdf;
    r.is_nl     = (c == ChNewline);
    r.is_letter = ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    r.is_digit  = (c >= 8'h30) && (c <= 8'h39);
    r.is_blank  = (c == ChSpace) || ((c >= 8'd9) && (c <= 8'd13));
    r.is_sign   = (c == ChPlus) || (c == ChMinus);
    r.is_minus  = (c == ChMinus);
    r.is_point  = (c == ChPoint);
    r.digit     = c[3:0];
    if (!r.is_letter) begin
      r.axis = AxisNone;
    end else if (u == ChUpperX) begin
      r.axis = AxisX;
    end else if (u == ChUpperY) begin
      r.axis = AxisY;
    end else if (u == ChUpperZ) begin
      r.axis = AxisZ;
    end else begin
      r.axis = AxisNone;
    end
    return r;
  endfunction

  // 10^(FracDigits - fc), a small constant table
  function automatic logic [ScaleW-1:0] gxfp_scale(input logic [FcW-1:0] fc);
    logic [ScaleW-1:0] p;
    p = ScaleW'(1);
    for (int i = 0; i < FracDigits; i++) begin
      if (FcW'(i) >= fc) begin
        p = ScaleW'(p * ScaleW'(10));
      end
    end
    return p;
  endfunction

endpackage

FILE: hdl/gcode_xyz_field_parser_core.sv
// G-code X/Y/Z field parser: input register, reader and store units, result register
// Usage:
//   Slave channel: one text character per beat on s_axis_tdata. Any letter closes
//   the open field; X, Y, Z (either case) open fields read as decimal numbers
//   scaled to thousandths, truncated toward zero and saturated to 32 bits. The
//   first of each letter in a line wins; values are kept across lines.
//   Master channel: one beat per newline character carrying the line kind and
//   the three retained coordinates. No beat for other characters.
//   Path: an accepted newline passes the input register, then the result register,
//   from which its beat is offered.
//   Throughput: one character per cycle unless a newline waits on a full result
//   register; the reader multiply-add by ten and the store scaling are combinational.
//   Reset: all control state, line tracking and the coordinates clear to zero;
//   no beat is offered until a newline arrives.
//   Stall: while a result waits in the result register, characters other than
//   newline keep flowing; a following newline waits in the input register,
//   and s_axis_tready drops only when that register is also full.
// Depends on gxfp_pkg, gxfp_num_unit, gxfp_coord_store.
module gcode_xyz_field_parser_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [gxfp_pkg::CharW-1:0]  s_axis_tdata,  // [7:0] text_char
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gxfp_pkg::OutW-1:0]   m_axis_tdata   // [1:0] line_kind, [33:2] x_thousandths,
                                                     // [65:34] y_thousandths,
                                                     // [97:66] z_thousandths, rest zero
);
  import gxfp_pkg::*;

  logic              in_valid_q;
  logic [CharW-1:0]  in_char_q;
  gxfp_cls_t         cls;
  logic              adv;
  logic              capture;
  gxfp_num_t         num;
  logic [KindW-1:0]  kind;
  logic [CoordW-1:0] x_d, y_d, z_d;
  logic              out_valid_q, out_valid_d;
  logic [OutBits-1:0] out_data_q;

  // classify the registered character
  assign cls = gxfp_classify(in_char_q);

  // a newline moves on only when the result register is free
  assign adv = in_valid_q && (!cls.is_nl || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
  end

  gxfp_num_unit u_num (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .capture_i (capture),
    .cls_i     (cls),
    .num_o     (num)
  );

  gxfp_coord_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .cls_i     (cls),
    .num_i     (num),
    .capture_o (capture),
    .kind_o    (kind),
    .x_d_o     (x_d),
    .y_d_o     (y_d),
    .z_d_o     (z_d)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && cls.is_nl) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cls.is_nl) begin
      out_data_q <= {z_d, y_d, x_d, kind};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_data_q);

endmodule

FILE: hdl/gxfp_num_unit.sv
// decimal number reader: sign, digit accumulation with saturation, fraction count
// depends on gxfp_pkg
module gxfp_num_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                capture_i,
  input  gxfp_pkg::gxfp_cls_t cls_i,
  output gxfp_pkg::gxfp_num_t num_o
);
  import gxfp_pkg::*;

  localparam logic [2:0] PhBefore = 3'd0;
  localparam logic [2:0] PhSign   = 3'd1;
  localparam logic [2:0] PhInt    = 3'd2;
  localparam logic [2:0] PhFrac   = 3'd3;
  localparam logic [2:0] PhStop   = 3'd4;

  logic [2:0]      phase_q, phase_d;
  gxfp_num_t       num_q, num_d;
  logic [MagW+3:0] sum;
  logic [MagW-1:0] mag_next;

  // saturating acc * 10 + digit
  always_comb begin
    sum      = {3'b000, num_q.mag, 1'b0} + {1'b0, num_q.mag, 3'b000}
             + {{MagW{1'b0}}, cls_i.digit};
    mag_next = (sum > {4'h0, MagLimit}) ? MagLimit : sum[MagW-1:0];
  end

  // per-character update of the reader
  always_comb begin
    phase_d = phase_q;
    num_d   = num_q;
    if (adv_i) begin
      if (cls_i.is_letter || cls_i.is_nl) begin
        phase_d   = PhBefore;
        num_d.neg = 1'b0;
        num_d.mag = '0;
        num_d.fc  = '0;
      end else if (capture_i) begin
        case (phase_q)
          PhBefore, PhSign, PhInt: begin
            if ((phase_q == PhBefore) && cls_i.is_blank) begin
              phase_d = phase_q;
            end else if ((phase_q == PhBefore) && cls_i.is_sign) begin
              num_d.neg = cls_i.is_minus;
              phase_d   = PhSign;
            end else if (cls_i.is_digit) begin
              num_d.mag = mag_next;
              phase_d   = PhInt;
            end else if (cls_i.is_point) begin
              phase_d = PhFrac;
            end else begin
              phase_d = PhStop;
            end
          end
          PhFrac: begin
            if (cls_i.is_digit) begin
              if (num_q.fc < FcW'(FracDigits)) begin
                num_d.mag = mag_next;
                num_d.fc  = num_q.fc + 1'b1;
              end
            end else begin
              phase_d = PhStop;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhBefore;
      num_q   <= '0;
    end else begin
      phase_q <= phase_d;
      num_q   <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

FILE: hdl/gxfp_coord_store.sv
// field closing, coordinate stores and per-line letter tracking
// depends on gxfp_pkg
module gxfp_coord_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  gxfp_pkg::gxfp_cls_t       cls_i,
  input  gxfp_pkg::gxfp_num_t       num_i,
  output logic                      capture_o,
  output logic [gxfp_pkg::KindW-1:0]  kind_o,
  output logic [gxfp_pkg::CoordW-1:0] x_d_o,
  output logic [gxfp_pkg::CoordW-1:0] y_d_o,
  output logic [gxfp_pkg::CoordW-1:0] z_d_o
);
  import gxfp_pkg::*;

  logic [1:0]        capture_q, capture_d;
  logic [2:0]        seen_q, seen_d;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [CoordW-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic [ProdW-1:0]  prod;
  logic [MagW-1:0]   mag_sc;
  logic [MagW-1:0]   val;
  logic [CoordW-1:0] val_c;
  logic              close_en;
  logic [2:0]        axis_bit;

  // scale to thousandths, saturate, apply sign
  always_comb begin
    prod   = ProdW'(num_i.mag) * ProdW'(gxfp_scale(num_i.fc));
    mag_sc = (prod > ProdW'(MagLimit)) ? MagLimit : prod[MagW-1:0];
    if (num_i.neg) begin
      val = (~mag_sc) + 1'b1;
    end else if (mag_sc == MagLimit) begin
      val = MagLimit - 1'b1;
    end else begin
      val = mag_sc;
    end
    val_c = CoordW'(signed'(val));
  end

  // letter and line bookkeeping
  always_comb begin
    close_en  = adv_i && (cls_i.is_letter || cls_i.is_nl) && (capture_q != AxisNone);
    capture_d = capture_q;
    seen_d    = seen_q;
    kind_d    = kind_q;
    x_d       = (close_en && (capture_q == AxisX)) ? val_c : x_q;
    y_d       = (close_en && (capture_q == AxisY)) ? val_c : y_q;
    z_d       = (close_en && (capture_q == AxisZ)) ? val_c : z_q;
    axis_bit  = 3'b001 << (cls_i.axis - 2'd1);
    if (adv_i) begin
      if (cls_i.is_nl) begin
        capture_d = AxisNone;
        seen_d    = '0;
        kind_d    = KindNone;
      end else if (cls_i.is_letter) begin
        capture_d = AxisNone;
        if ((cls_i.axis != AxisNone) && ((seen_q & axis_bit) == 3'b000)) begin
          seen_d    = seen_q | axis_bit;
          capture_d = cls_i.axis;
          if (kind_q == KindNone) begin
            kind_d = (cls_i.axis == AxisZ) ? KindZ : KindXy;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_q <= AxisNone;
      seen_q    <= '0;
      kind_q    <= KindNone;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
    end else begin
      capture_q <= capture_d;
      seen_q    <= seen_d;
      kind_q    <= kind_d;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
    end
  end

  assign capture_o = (capture_q != AxisNone);
  assign kind_o    = kind_q;
  assign x_d_o     = x_d;
  assign y_d_o     = y_d;
  assign z_d_o     = z_d;

endmodule

FILE: hdl/gxfp_checker.sv
// port-level checker for the field parser, bound to the top level
// depends on gxfp_pkg and gcode_xyz_field_parser_core_assert.svh
`include "gcode_xyz_field_parser_core_assert.svh"

module gxfp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [gxfp_pkg::CharW-1:0] s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [gxfp_pkg::OutW-1:0]  m_axis_tdata
);
  import gxfp_pkg::*;

  logic nl_beat;
  assign nl_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == ChNewline);

  // no result offered while in reset
  `GXFP_ASSERT_ALL(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "result offered in reset")

  // a newline beat has a result offered once it has passed the input and result registers
  `GXFP_ASSERT_RUN(a_nl_result, nl_beat |-> ##2 m_axis_tvalid, "newline gave no result")

  // the line kind is never the unused code
  `GXFP_ASSERT_RUN(a_kind_code, m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3),
                   "bad line kind")

  // a stalled result holds
  `GXFP_ASSERT_RUN(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind gcode_xyz_field_parser_core gxfp_checker u_gxfp_checker (.*);

FILE: verif/gcode_xyz_field_parser_core_tb.sv
// testbench of gcode_xyz_field_parser_core: a table of g-code lines, then random lines
// checked beat by beat against typed-in results or a behavioural line parser kept in this file
// depends on gxfp_pkg and gcode_xyz_field_parser_core
`timescale 1ns / 100ps

module gcode_xyz_field_parser_core_tb;

  import gxfp_pkg::CharW;
  import gxfp_pkg::OutW;
  import gxfp_pkg::FracDigits;
  import gxfp_pkg::ChNewline;
  import gxfp_pkg::ChSpace;
  import gxfp_pkg::ChPlus;
  import gxfp_pkg::ChMinus;
  import gxfp_pkg::ChPoint;
  import gxfp_pkg::ChUpperX;
  import gxfp_pkg::ChUpperY;
  import gxfp_pkg::ChUpperZ;
  import gxfp_pkg::AxisNone;
  import gxfp_pkg::AxisX;
  import gxfp_pkg::AxisY;
  import gxfp_pkg::AxisZ;
  import gxfp_pkg::KindNone;
  import gxfp_pkg::KindXy;
  import gxfp_pkg::KindZ;

  // characters not in the package
  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChCr     = 8'd13;
  localparam logic [7:0] ChDigit0 = "0";
  localparam logic [7:0] ChDigit9 = "9";
  localparam logic [7:0] ChUpperA = "A";
  localparam logic [7:0] ChLowerA = "a";
  localparam logic [7:0] ChLowerZ = "z";

  localparam logic [63:0] MagCap     = 64'h8000_0000;
  localparam int          RandChars  = 1150;
  localparam int          HoldCycles = 300;
  localparam int          NumRows    = 15;

  typedef enum logic [2:0] {
    PhBefore, PhSigned, PhInteger, PhFraction, PhStopped
  } num_phase_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } line_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fixed;
    line_res_t  res;
  } text_beat_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [CharW-1:0]     s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutW-1:0]      m_axis_tdata;

  // beat on the slave side, with its typed-in line result if any
  text_beat_t           cur_beat;

  // behavioural parser state
  logic [1:0]           fld_axis;
  num_phase_e           num_phase;
  logic                 num_neg;
  logic [63:0]          num_mag;
  int                   num_frac;
  logic [2:0]           line_seen;
  logic [1:0]           line_kind;
  logic signed [31:0]   coord_x;
  logic signed [31:0]   coord_y;
  logic signed [31:0]   coord_z;

  line_res_t            pending_lines[$];
  text_beat_t           text_q[$];
  int                   errors;
  int                   chars_taken;
  int                   lines_checked;
  int                   lines_typed;

  logic [7:0] axis_letters[6] = '{"X", "Y", "Z", "x", "y", "z"};
  logic [7:0] blank_chars[5]  = '{8'd9, 8'd11, 8'd12, ChCr, ChSpace};

  // directed lines; typed-in results only for the first four rows: reset, a plain line, extremes, saturation
  string     row_text[NumRows] = '{
    "\n",
    "G1 X12.5 Y-3.25 Z0.1\n",
    "z2147483.647 x-2147483.648\n",
    "X99999999999 Y-99999999999\n",
    "X\013\014\015 +7.123456e5 Y\n",
    "X- Y. Z\n",
    "X-0.000\n",
    "Z5 X1 Z9 x2\n",
    "A1 B2 G0 M3\n",
    "X1 2\n",
    "X3\200 5\n",
    "\377 X-.5 E5\n",
    "Y+\t7\n",
    "X1.2.3 y0.0009 Z-0.0019\n",
    "x+ Y\n"
  };
  logic      row_fixed[NumRows] = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
  line_res_t row_res[NumRows] = '{
    '{KindNone, 32'sd0, 32'sd0, 32'sd0},
    '{KindXy, 32'sd12500, -32'sd3250, 32'sd100},
    '{KindZ, -32'sd2147483648, -32'sd3250, 32'sd2147483647},
    '{KindXy, 32'sd2147483647, -32'sd2147483648, 32'sd2147483647},
    '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0
  };

  gcode_xyz_field_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // magnitude times ten plus digit, saturating at 2^31
  function automatic logic [63:0] mag_mul_add(input logic [63:0] acc, input logic [63:0] d);
    if (acc > (MagCap - d) / 10) begin
      return MagCap;
    end
    return acc * 10 + d;
  endfunction

  // scale the open field to thousandths, clip and store it
  task automatic close_open_field();
    logic [63:0] m;
    logic [63:0] v;
    int          k;
    if (fld_axis == AxisNone) begin
      return;
    end
    m = num_mag;
    for (k = num_frac; k < FracDigits; k++) begin
      m = mag_mul_add(m, 64'd0);
    end
    if (num_neg) begin
      if (m > MagCap) m = MagCap;
      v = 64'd0 - m;
    end else begin
      if (m > MagCap - 1) m = MagCap - 1;
      v = m;
    end
    case (fld_axis)
      AxisX:   coord_x = v[31:0];
      AxisY:   coord_y = v[31:0];
      default: coord_z = v[31:0];
    endcase
    fld_axis = AxisNone;
  endtask

  task automatic restart_number();
    num_phase = PhBefore;
    num_neg   = 1'b0;
    num_mag   = '0;
    num_frac  = 0;
  endtask

  // one character of an x, y or z field
  task automatic read_number_char(input logic [7:0] c);
    logic is_digit;
    logic is_blank;
    is_digit = (c >= ChDigit0) && (c <= ChDigit9);
    is_blank = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    case (num_phase)
      PhBefore, PhSigned, PhInteger: begin
        if (num_phase == PhBefore && is_blank) begin
          // leading blank skipped
        end else if (num_phase == PhBefore && (c == ChPlus || c == ChMinus)) begin
          num_neg   = (c == ChMinus);
          num_phase = PhSigned;
        end else if (is_digit) begin
          num_mag   = mag_mul_add(num_mag, 64'(c - ChDigit0));
          num_phase = PhInteger;
        end else if (c == ChPoint) begin
          num_phase = PhFraction;
        end else begin
          num_phase = PhStopped;
        end
      end
      PhFraction: begin
        if (is_digit) begin
          // digits past the third are dropped
          if (num_frac < FracDigits) begin
            num_mag = mag_mul_add(num_mag, 64'(c - ChDigit0));
            num_frac++;
          end
        end else begin
          num_phase = PhStopped;
        end
      end
      default: ;
    endcase
  endtask

  // one accepted character; a newline yields the line result
  task automatic parse_char(input logic [7:0] c, output logic emitted, output line_res_t res);
    logic [7:0] u;
    logic [1:0] ax;
    u       = c & 8'hdf;
    emitted = 1'b0;
    res     = '0;
    if (c == ChNewline) begin
      close_open_field();
      emitted   = 1'b1;
      res       = '{line_kind, coord_x, coord_y, coord_z};
      line_seen = '0;
      line_kind = KindNone;
      restart_number();
    end else if ((c >= ChUpperA && c <= ChUpperZ) || (c >= ChLowerA && c <= ChLowerZ)) begin
      close_open_field();
      restart_number();
      if (u == ChUpperX) ax = AxisX;
      else if (u == ChUpperY) ax = AxisY;
      else if (u == ChUpperZ) ax = AxisZ;
      else ax = AxisNone;
      // only the first of each coordinate letter in a line opens a field
      if (ax != AxisNone && !line_seen[ax-1]) begin
        line_seen[ax-1] = 1'b1;
        fld_axis        = ax;
        if (line_kind == KindNone) begin
          line_kind = (ax == AxisZ) ? KindZ : KindXy;
        end
      end
    end else if (fld_axis != AxisNone) begin
      read_number_char(c);
    end
  endtask

  task automatic push_char(input logic [7:0] c);
    text_q.insert(text_q.size(), '{c, 1'b0, line_res_t'('0)});
  endtask

  // random line: mostly well-formed fields, some noise and broken numbers
  task automatic add_random_line();
    int         fields;
    int         r;
    int         nd;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      nd = $urandom_range(1, 24);
      repeat (nd) begin
        c = 8'($urandom_range(0, 255));
        if (c != ChNewline) push_char(c);
      end
    end else begin
      fields = (r < 8) ? $urandom_range(25, 40) : $urandom_range(0, 4);
      repeat (fields) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          push_char(axis_letters[$urandom_range(0, 5)]);
        end else if (r < 92) begin
          push_char(8'($urandom_range(0, 1) ? $urandom_range(ChUpperA, ChUpperZ)
                                            : $urandom_range(ChLowerA, ChLowerZ)));
        end
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) push_char(blank_chars[$urandom_range(0, 4)]);
        end
        r = $urandom_range(0, 9);
        if (r < 3) push_char(ChMinus);
        else if (r < 4) push_char(ChPlus);
        nd = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 4);
        repeat (nd) push_char(8'($urandom_range(ChDigit0, ChDigit9)));
        if ($urandom_range(0, 1)) begin
          push_char(ChPoint);
          repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(ChDigit0, ChDigit9)));
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
          push_char($urandom_range(0, 1) ? "e" : "E");
          push_char(8'($urandom_range(ChDigit0, ChDigit9)));
        end else if (r == 1) begin
          c = 8'($urandom_range(0, 255));
          if (c != ChNewline) push_char(c);
        end else if (r == 2) begin
          push_char(ChPoint);
        end
        if ($urandom_range(0, 2) == 0) push_char(ChSpace);
      end
    end
    push_char(ChNewline);
  endtask

  // gap before the next beat: mostly none, sometimes long, with gap-free bursts
  int send_burst;
  function automatic int pick_send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(5, 25);
    send_burst = 60;
    return 0;
  endfunction

  // receiver: random stalls plus one long hold-off once the stream is busy
  initial begin
    int   rx_left;
    int   r;
    logic hold_done;
    m_axis_tready = 1'b0;
    rx_left       = 0;
    hold_done     = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && chars_taken >= 700) begin
        hold_done     = 1'b1;
        m_axis_tready <= 1'b0;
        rx_left       = HoldCycles;
      end else if (rx_left > 0) begin
        rx_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          m_axis_tready <= 1'b1;
          rx_left       = $urandom_range(0, 7);
        end else if (r < 85) begin
          m_axis_tready <= 1'b0;
          rx_left       = $urandom_range(0, 2);
        end else if (r < 95) begin
          m_axis_tready <= 1'b1;
          rx_left       = $urandom_range(20, 60);
        end else begin
          m_axis_tready <= 1'b0;
          rx_left       = $urandom_range(10, 40);
        end
      end
    end
  end

  // check master beats and follow slave beats at each rising edge
  always @(posedge clk_i) begin
    line_res_t  want;
    line_res_t  got;
    line_res_t  res;
    logic       emitted;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34],
                m_axis_tdata[97:66]};
        if (pending_lines.size() == 0) begin
          note_mismatch("result beat with no line pending");
        end else begin
          want = pending_lines.pop_front();
          if (got.kind !== want.kind)
            note_mismatch($sformatf("line %0d kind got %0d want %0d",
                                    lines_checked, got.kind, want.kind));
          if (got.x !== want.x)
            note_mismatch($sformatf("line %0d x got %0d want %0d",
                                    lines_checked, got.x, want.x));
          if (got.y !== want.y)
            note_mismatch($sformatf("line %0d y got %0d want %0d",
                                    lines_checked, got.y, want.y));
          if (got.z !== want.z)
            note_mismatch($sformatf("line %0d z got %0d want %0d",
                                    lines_checked, got.z, want.z));
          if (m_axis_tdata[OutW-1:98] !== '0)
            note_mismatch($sformatf("line %0d padding bits not zero", lines_checked));
          lines_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        parse_char(s_axis_tdata, emitted, res);
        chars_taken++;
        if (emitted) begin
          // typed-in rows are checked against the table, not the parser
          if (cur_beat.fixed) begin
            pending_lines.insert(pending_lines.size(), cur_beat.res);
            lines_typed++;
          end else begin
            pending_lines.insert(pending_lines.size(), res);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int         i;
    int         j;
    int         gap;
    int         rand_chars;
    int         wait_left;
    string      s;
    text_beat_t b;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cur_beat      = '0;
    errors        = 0;
    chars_taken   = 0;
    lines_checked = 0;
    lines_typed   = 0;
    send_burst    = 0;

    fld_axis  = AxisNone;
    restart_number();
    line_seen = '0;
    line_kind = KindNone;
    coord_x   = '0;
    coord_y   = '0;
    coord_z   = '0;

    // directed table, then random lines
    for (i = 0; i < NumRows; i++) begin
      s = row_text[i];
      for (j = 0; j < s.len(); j++) begin
        b = '{s[j], 1'b0, line_res_t'('0)};
        if (j == s.len() - 1 && row_fixed[i]) begin
          b.fixed = 1'b1;
          b.res   = row_res[i];
        end
        text_q.insert(text_q.size(), b);
      end
    end
    rand_chars = text_q.size();
    while (text_q.size() - rand_chars < RandChars) add_random_line();

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sender
    foreach (text_q[k]) begin
      gap = pick_send_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= text_q[k].ch;
      cur_beat      <= text_q[k];
      do @(posedge clk_i); while (!s_axis_tready);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then wait out any stray beat
    while (pending_lines.size() > 0) @(posedge clk_i);
    wait_left = 8;
    while (wait_left > 0) begin
      @(posedge clk_i);
      wait_left--;
    end

    $display("covered %0d characters: %0d table rows and random lines, %0d results checked",
             chars_taken, NumRows, lines_checked);
    $display("%0d results checked against typed values, %0d mismatches",
             lines_typed, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
